>>> hw/rtl/sicc_pkg.sv
// Package for the scan intensity cluster centroid block.
// Holds widths, register map, CORDIC constants and the controller/datapath command types.
`default_nettype none
package sicc_pkg;
    localparam int MaxSamples  = 2048;
    localparam int IdxW        = $clog2(MaxSamples);
    localparam int AngleBits   = 16;
    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps);
    localparam int CntW        = 12;
    localparam int SumW        = 29;
    localparam int OutW        = 17;
    localparam int CwW         = 34;
    localparam int QuoW        = 30;
    localparam int DivSteps    = 30;
    localparam int DivCntW     = 5;
    localparam logic signed [CwW-1:0] CordicGain = CwW'(652032874);

    localparam logic [15:0] LimitReset = 16'd3000;
    localparam logic [15:0] StartReset = 16'h8000;
    localparam logic [15:0] StepReset  = 16'd32;

    localparam logic [3:0] AddrLimit = 4'h0;
    localparam logic [3:0] AddrStart = 4'h4;
    localparam logic [3:0] AddrStep  = 4'h8;

    function automatic logic signed [CwW-1:0] atan_entry(input logic [StepW-1:0] i);
        logic signed [CwW-1:0] r;
        begin
            case (i)
                4'd0:  r = CwW'(536870912);
                4'd1:  r = CwW'(316933406);
                4'd2:  r = CwW'(167458907);
                4'd3:  r = CwW'(85004756);
                4'd4:  r = CwW'(42667331);
                4'd5:  r = CwW'(21354465);
                4'd6:  r = CwW'(10679838);
                4'd7:  r = CwW'(5340245);
                4'd8:  r = CwW'(2670163);
                4'd9:  r = CwW'(1335087);
                4'd10: r = CwW'(667544);
                4'd11: r = CwW'(333772);
                4'd12: r = CwW'(166886);
                4'd13: r = CwW'(83443);
                4'd14: r = CwW'(41721);
                default: r = CwW'(20860);
            endcase
            return r;
        end
    endfunction

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic cordic_start;
        logic cordic_step;
        logic mul_x;
        logic mul_y;
        logic accum;
        logic div_start;
        logic div_step;
        logic capture;
        logic index_adv;
    } sicc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic above;
        logic last;
        logic open_after;
        logic cordic_done;
        logic div_done;
    } sicc_stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/scan_intensity_cluster_centroid_top.sv
// Top level: APB register file, controller and datapath.
// Depends on sicc_pkg, sicc_ctrl, sicc_datapath.
`default_nettype none
// One sample is taken at a time. A sample below the limit with no open cluster
// visits only decide and close; an above-limit sample adds 16 CORDIC iterations
// on one shared rotator plus the product and accumulate states; a sample that
// closes a cluster adds a bit-serial divide for both axes in parallel. The result
// register frees the input side while a result waits, unless a second result is
// ready before the first is taken. Registers at 0x0 limit, 0x4 start, 0x8 step.
module scan_intensity_cluster_centroid_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] range_mm,
    input  wire logic [15:0] intensity,
    input  wire logic        scan_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [16:0] centroid_x,
    output logic signed [16:0] centroid_y,
    output logic [11:0]      point_count,
    output logic             closed_by_end
);
    import sicc_pkg::*;

    logic [15:0] limit_reg, start_reg, step_reg;
    sicc_cmd_t  cmd;
    sicc_stat_t stat;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LimitReset;
            start_reg <= StartReset;
            step_reg  <= StepReset;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                AddrLimit: limit_reg <= pwdata[15:0];
                AddrStart: start_reg <= pwdata[15:0];
                AddrStep:  step_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (paddr)
            AddrLimit: prdata = {16'h0, limit_reg};
            AddrStart: prdata = {16'h0, start_reg};
            AddrStep:  prdata = {16'h0, step_reg};
            default:   prdata = '0;
        endcase
    end

    sicc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    sicc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .range_mm(range_mm), .intensity(intensity), .scan_last(scan_last),
        .intensity_limit(limit_reg), .start_angle(start_reg), .angle_step(step_reg),
        .res_x(centroid_x), .res_y(centroid_y),
        .res_count(point_count), .res_end(closed_by_end)
    );
endmodule
`default_nettype wire

>>> hw/rtl/sicc_datapath.sv
// Datapath: sample registers, sequential CORDIC, product stage, accumulators, divider.
// Depends on sicc_pkg.
`default_nettype none
module sicc_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sicc_pkg::sicc_cmd_t cmd,
    output sicc_pkg::sicc_stat_t   stat,
    input  wire logic [15:0]       range_mm,
    input  wire logic [15:0]       intensity,
    input  wire logic              scan_last,
    input  wire logic [15:0]       intensity_limit,
    input  wire logic [15:0]       start_angle,
    input  wire logic [15:0]       angle_step,
    output logic signed [16:0]     res_x,
    output logic signed [16:0]     res_y,
    output logic [11:0]            res_count,
    output logic                   res_end
);
    import sicc_pkg::*;

    logic [15:0]            range_reg;
    logic                   above_reg, last_reg;
    logic [IdxW-1:0]        index_reg;
    logic [AngleBits-1:0]   angle_reg;
    logic                   flip_reg;
    logic signed [CwW-1:0]  cx_reg, cy_reg, cz_reg;
    logic [StepW-1:0]       step_reg;
    logic signed [17:0]     sin_reg;
    logic signed [35:0]     prod_reg;
    logic signed [SumW-1:0] sum_x_reg, sum_y_reg;
    logic [CntW-1:0]        size_reg;
    logic [QuoW-1:0]        qx_reg, qy_reg, rx_reg, ry_reg;
    logic                   nx_reg, ny_reg;
    logic [DivCntW-1:0]     dcnt_reg;
    logic [CntW-1:0]        dsz_reg;
    logic                   dend_reg;
    logic signed [16:0]     res_x_reg, res_y_reg;
    logic [11:0]            res_count_reg;
    logic                   res_end_reg;

    logic [31:0] phase;
    logic        flip_c;
    logic [31:0] phase_f;
    logic signed [CwW-1:0] shy, shx, at;
    logic signed [CwW-1:0] fx, fy;
    logic signed [17:0] q_x, q_y;
    logic signed [35:0] pt;
    logic signed [SumW-1:0] pt_ext;
    logic [QuoW-1:0] ax, ay, trx, try_;
    logic [QuoW:0] dx, dy;
    logic [AngleBits-1:0] ang_c;

    // Angle for the current sample
    assign ang_c = AngleBits'({{16{start_angle[15]}}, start_angle}
                   + 32'(index_reg) * 32'(angle_step));
    assign phase  = 32'(angle_reg) << (32 - AngleBits);
    assign flip_c = phase[31] ^ phase[30];
    assign phase_f = phase + (flip_c ? 32'h8000_0000 : 32'h0);

    assign shy = cy_reg >>> step_reg;
    assign shx = cx_reg >>> step_reg;
    assign at  = atan_entry(step_reg);

    assign fx = (cx_reg + CwW'(16384)) >>> 15;
    assign fy = (cy_reg + CwW'(16384)) >>> 15;
    assign q_x = flip_reg ? -18'(fx) : 18'(fx);
    assign q_y = flip_reg ? -18'(fy) : 18'(fy);

    // Truncate product toward zero by 2^15
    assign pt = prod_reg + ((prod_reg < 0) ? 36'sd32767 : 36'sd0);
    assign pt_ext = SumW'(pt >>> 15);

    assign ax = sum_x_reg[SumW-1] ? QuoW'(-sum_x_reg) : QuoW'(sum_x_reg);
    assign ay = sum_y_reg[SumW-1] ? QuoW'(-sum_y_reg) : QuoW'(sum_y_reg);
    assign dx = {rx_reg, qx_reg[QuoW-1]} - (QuoW+1)'(dsz_reg);
    assign dy = {ry_reg, qy_reg[QuoW-1]} - (QuoW+1)'(dsz_reg);
    assign trx = dx[QuoW] ? QuoW'({rx_reg, qx_reg[QuoW-1]}) : dx[QuoW-1:0];
    assign try_ = dy[QuoW] ? QuoW'({ry_reg, qy_reg[QuoW-1]}) : dy[QuoW-1:0];

    assign stat.above = above_reg;
    assign stat.last = last_reg;
    assign stat.open_after = (size_reg != '0) && (!above_reg || last_reg);
    assign stat.cordic_done = (step_reg == StepW'(CordicSteps - 1));
    assign stat.div_done = (dcnt_reg == DivCntW'(DivSteps - 1));

    // Control state: index and cluster count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            size_reg  <= '0;
        end
        else
        begin
            if (cmd.index_adv)
                index_reg <= last_reg ? '0 : index_reg + 1'b1;
            if (cmd.accum)
                size_reg <= size_reg + 1'b1;
            if (cmd.div_start)
                size_reg <= '0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            range_reg <= range_mm;
            above_reg <= intensity > intensity_limit;
            last_reg  <= scan_last || (index_reg == IdxW'(MaxSamples - 1));
            angle_reg <= ang_c;
        end
        if (cmd.cordic_start)
        begin
            flip_reg <= flip_c;
            cx_reg   <= CordicGain;
            cy_reg   <= '0;
            cz_reg   <= CwW'($signed(phase_f));
            step_reg <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (cz_reg >= 0)
            begin
                cx_reg <= cx_reg - shy;
                cy_reg <= cy_reg + shx;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + shy;
                cy_reg <= cy_reg - shx;
                cz_reg <= cz_reg + at;
            end
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.mul_x)
        begin
            sin_reg  <= q_y;
            prod_reg <= $signed({2'b0, range_reg}) * q_x;
        end
        if (cmd.mul_y)
        begin
            sum_x_reg <= sum_x_reg + pt_ext;
            prod_reg  <= $signed({2'b0, range_reg}) * sin_reg;
        end
        if (cmd.accum)
            sum_y_reg <= sum_y_reg + pt_ext;
        if (cmd.load && size_reg == '0)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        if (cmd.div_start)
        begin
            qx_reg <= ax;
            qy_reg <= ay;
            rx_reg <= '0;
            ry_reg <= '0;
            nx_reg <= sum_x_reg[SumW-1];
            ny_reg <= sum_y_reg[SumW-1];
            dsz_reg <= size_reg;
            dend_reg <= above_reg;
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rx_reg <= trx;
            ry_reg <= try_;
            qx_reg <= {qx_reg[QuoW-2:0], ~dx[QuoW]};
            qy_reg <= {qy_reg[QuoW-2:0], ~dy[QuoW]};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.capture)
        begin
            res_x_reg <= nx_reg ? -17'(qx_reg) : 17'(qx_reg);
            res_y_reg <= ny_reg ? -17'(qy_reg) : 17'(qy_reg);
            res_count_reg <= dsz_reg;
            res_end_reg <= dend_reg;
        end
    end

    assign res_x = res_x_reg;
    assign res_y = res_y_reg;
    assign res_count = res_count_reg;
    assign res_end = res_end_reg;

    // Cluster size never grows past the sample limit
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CntW'(MaxSamples))
        else $error("cluster size overflow");
    // Divider never starts on an empty cluster
    a_div_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> size_reg != '0)
        else $error("divide on empty cluster");
    // Index wraps after a last sample
    a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.index_adv && last_reg) |=> index_reg == '0)
        else $error("index did not restart");
endmodule
`default_nettype wire

>>> hw/rtl/sicc_ctrl.sv
// Controller state machine sequencing load, CORDIC, products, divide and output.
// Depends on sicc_pkg.
`default_nettype none
module sicc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output sicc_pkg::sicc_cmd_t       cmd,
    input  wire sicc_pkg::sicc_stat_t stat
);
    import sicc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_CORDIC, S_MULX, S_MULY, S_ACC, S_CLOSE, S_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.above)
                begin
                    cmd.cordic_start = 1'b1;
                    state_next = S_CORDIC;
                end
                else
                    state_next = S_CLOSE;
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_done)
                    state_next = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul_x = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum = 1'b1;
                state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (stat.open_after)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.index_adv = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.capture = 1'b1;
                    cmd.index_adv = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.capture)
        else $error("result overwritten");
    // Only one item in flight
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    // Divider runs only after a close decision
    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("divider sequence broken");
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Testbench for scan_intensity_cluster_centroid_top: directed table, then random scans.
// Depends on sicc_pkg for register addresses; predicts centroids with its own CORDIC model.
`default_nettype none
module testbench;
    import sicc_pkg::*;

    localparam int TimeoutCycles = 20000;

    typedef struct packed {
        logic signed [16:0] cx;
        logic signed [16:0] cy;
        logic [11:0]        cnt;
        logic               by_end;
    } centroid_t;

    typedef struct {
        logic [15:0] rng;
        logic [15:0] inten;
        logic        last;
        logic        has_exp;
        centroid_t   exp_c;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] range_mm = '0, intensity = '0;
    logic scan_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [16:0] centroid_x, centroid_y;
    logic [11:0] point_count;
    logic closed_by_end;

    scan_intensity_cluster_centroid_top dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [15:0] lim_q = LimitReset, start_q = StartReset, step_q = StepReset;
    int unsigned idx_q = 0;
    longint sx_q = 0, sy_q = 0;
    int unsigned csize_q = 0;
    centroid_t centroid_q[$];
    int errors = 0;
    int idle_cycles = 0;
    logic hold_long = 1'b0;

    // directed rows from reset state; the cluster closed on the second row is read by hand
    // (start angle -32768: cos -1, sin 0, so range 1000 gives (-1000, 0))
    row_t dir_rows[10] = '{
        '{16'd1000, 16'd3001, 1'b0, 1'b0, '0},
        '{16'd0, 16'd3000, 1'b0, 1'b1, '{-17'sd1000, 17'sd0, 12'd1, 1'b0}},
        '{16'd0, 16'd0, 1'b0, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
        '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
        '{16'h0, 16'h0, 1'b1, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b1, 1'b0, '0},
        '{16'd7, 16'd0, 1'b1, 1'b0, '0}
    };

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_cos_sin(logic [15:0] ang, output longint c, output longint s);
        longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41721, 20860};
        logic [31:0] ph;
        logic flip;
        longint x, y, z, nx, ny;
        ph = {ang, 16'h0};
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        if (flip) ph = ph + 32'h8000_0000;
        z = longint'(signed'(ph));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - fshift(y, i); ny = y + fshift(x, i); z -= atan_tab[i];
            end
            else
            begin
                nx = x + fshift(y, i); ny = y - fshift(x, i); z += atan_tab[i];
            end
            x = nx; y = ny;
        end
        x = fshift(x + 16384, 15);
        y = fshift(y + 16384, 15);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // advance the cluster model by one sample; return 1 when a centroid closes
    function automatic bit cluster_step(logic [15:0] rng, logic [15:0] inten, logic lst,
                                        output centroid_t res);
        bit last_s, above;
        logic [15:0] ang;
        longint c, s;
        last_s = lst || (idx_q >= MaxSamples - 1);
        above = inten > lim_q;
        res = '0;
        cluster_step = 0;
        if (above)
        begin
            ang = 16'(int'(signed'(start_q)) + idx_q * int'(step_q));
            cordic_cos_sin(ang, c, s);
            sx_q += (longint'(rng) * c) / 32768;
            sy_q += (longint'(rng) * s) / 32768;
            csize_q++;
        end
        if (csize_q > 0 && (!above || last_s))
        begin
            res.cx = 17'(sx_q / longint'(csize_q));
            res.cy = 17'(sy_q / longint'(csize_q));
            res.cnt = 12'(csize_q);
            res.by_end = above;
            cluster_step = 1;
            sx_q = 0; sy_q = 0; csize_q = 0;
        end
        idx_q = last_s ? 0 : idx_q + 1;
    endfunction

    task automatic reg_write(logic [3:0] a, logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            AddrLimit: lim_q = v;
            AddrStart: start_q = v;
            default:   step_q = v;
        endcase
    endtask

    // drain outstanding centroids, then let the block finish a silent sample
    task automatic wait_idle();
        while (centroid_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // present one sample and hold it until taken
    task automatic send_sample(logic [15:0] rng, logic [15:0] inten, logic lst,
                               logic has_exp, centroid_t exp_c);
        centroid_t res;
        bit got;
        range_mm <= rng; intensity <= inten; scan_last <= lst; in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        got = cluster_step(rng, inten, lst, res);
        if (has_exp && (!got || res != exp_c))
        begin
            $display("%0t directed row: expected %p, predicted %p", $time, exp_c, res);
            errors++;
        end
        if (got) centroid_q = {centroid_q, res};
    endtask

    task automatic gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // compare each centroid transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (centroid_q.size() == 0)
            begin
                $display("%0t unexpected centroid: expected none, actual %0d %0d %0d %0d",
                         $time, centroid_x, centroid_y, point_count, closed_by_end);
                errors++;
            end
            else
            begin
                automatic centroid_t e = centroid_q.pop_front();
                if (centroid_x !== e.cx || centroid_y !== e.cy ||
                    point_count !== e.cnt || closed_by_end !== e.by_end)
                begin
                    $display("%0t mismatch: expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                             $time, e.cx, e.cy, e.cnt, e.by_end,
                             centroid_x, centroid_y, point_count, closed_by_end);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 99);
        if (hold_long) out_stall <= 1'b1;
        else if (mode < 30) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > TimeoutCycles)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // random scan with mostly above-limit runs
    task automatic random_scan(int len, int gap_pct);
        logic [15:0] inten, rng;
        int burst;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            rng = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65530, 65535))
                                              : 16'($urandom);
            if ($urandom_range(0, 99) < 70) inten = 16'($urandom_range(lim_q, 65535));
            else inten = 16'($urandom_range(0, lim_q));
            send_sample(rng, inten, i == len - 1, 1'b0, '0);
            if (--burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 99) < gap_pct) gap($urandom_range(1, 30));
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (dir_rows[i])
            send_sample(dir_rows[i].rng, dir_rows[i].inten, dir_rows[i].last,
                        dir_rows[i].has_exp, dir_rows[i].exp_c);
        in_valid <= 1'b0;
        wait_idle();

        // extreme registers, then a full-length scan forcing the too-long case
        reg_write(AddrLimit, 16'd0);
        reg_write(AddrStart, 16'h7FFF);
        reg_write(AddrStep, 16'hFFFF);
        for (int i = 0; i < MaxSamples + 3; i++)
            send_sample(16'($urandom), 16'($urandom_range(1, 65535)), 1'b0, 1'b0, '0);
        send_sample(16'd5, 16'd0, 1'b1, 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();
        reg_write(AddrLimit, 16'hFFFF);
        send_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0);
        in_valid <= 1'b0;
        wait_idle();

        // random phases over several register settings
        sent = 0;
        for (int ph = 0; sent < 300; ph++)
        begin
            reg_write(AddrLimit, (ph % 4 == 0) ? 16'd0 : 16'($urandom_range(0, 40000)));
            reg_write(AddrStart, (ph % 5 == 1) ? 16'h8000 : 16'($urandom));
            reg_write(AddrStep, (ph % 6 == 2) ? 16'd0 : 16'($urandom));
            if (ph == 2)
            begin
                fork
                    begin
                        hold_long = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_long = 1'b0;
                    end
                    random_scan(60, 0);
                join
                sent += 60;
            end
            else
            begin
                automatic int n = $urandom_range(5, 80);
                random_scan(n, (ph % 3 == 0) ? 0 : 60);
                sent += n;
            end
            wait_idle();
        end

        while (centroid_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> scan_intensity_cluster_centroid_top.f
hw/rtl/sicc_pkg.sv
hw/rtl/sicc_datapath.sv
hw/rtl/sicc_ctrl.sv
hw/rtl/scan_intensity_cluster_centroid_top.sv
tb/sv/testbench.sv
